>>> src/humidity_temp_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder assertion macros
// clocked assertion wrappers for the frame decoder, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

`define HTFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("htfd assertion failed");

`define HTFD_ASSERT_NEVER(lbl, clk, rstn, expr) \
  `HTFD_ASSERT(lbl, clk, rstn, !(expr))

`else

`define HTFD_ASSERT(lbl, clk, rstn, prop)

`define HTFD_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

>>> src/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// shared types and constants of the humidity and temperature frame decoder
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // byte position inside the six byte response frame
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_e;

  // one checked frame handed from front to back
  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
    logic        temp_bad;
    logic        hum_bad;
  } frame_t;

endpackage

>>> src/htfd_front.sv
// ----------------------------------------------------------------------------
// htfd_front
// byte intake: tracks frame position, runs crc-8, assembles raw words
// ----------------------------------------------------------------------------
module htfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic [7:0]          s_byte_i,
  input  logic                s_start_i,
  output logic                s_ready_o,
  input  logic                full_i,
  output logic                push_o,
  output htfd_pkg::frame_t    frame_o
);

  htfd_pkg::pos_e pos_q, pos_d, pos_cur;
  logic [7:0]     crc_q, crc_d, crc_cur, crc_next;
  logic [7:0]     high_q, high_d;
  logic [15:0]    raw_temp_q, raw_temp_d;
  logic [15:0]    raw_hum_q, raw_hum_d;
  logic           temp_bad_q, temp_bad_d;
  logic           accept;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  assign s_ready_o = !full_i;
  assign accept    = s_valid_i && s_ready_o;

  // frame start and unused codes restart the frame
  always_comb begin
    pos_cur = htfd_pkg::POS_T_HI;
    crc_cur = htfd_pkg::CRC_INIT;
    if (!s_start_i) begin
      case (pos_q)
        htfd_pkg::POS_T_HI, htfd_pkg::POS_T_LO, htfd_pkg::POS_T_CRC,
        htfd_pkg::POS_H_HI, htfd_pkg::POS_H_LO, htfd_pkg::POS_H_CRC: begin
          pos_cur = pos_q;
          crc_cur = crc_q;
        end
        default: begin
          pos_cur = htfd_pkg::POS_T_HI;
          crc_cur = htfd_pkg::CRC_INIT;
        end
      endcase
    end
  end

  assign crc_next = crc8_feed(crc_cur, s_byte_i);

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      case (pos_cur)
        htfd_pkg::POS_T_HI:  pos_d = htfd_pkg::POS_T_LO;
        htfd_pkg::POS_T_LO:  pos_d = htfd_pkg::POS_T_CRC;
        htfd_pkg::POS_T_CRC: pos_d = htfd_pkg::POS_H_HI;
        htfd_pkg::POS_H_HI:  pos_d = htfd_pkg::POS_H_LO;
        htfd_pkg::POS_H_LO:  pos_d = htfd_pkg::POS_H_CRC;
        default:             pos_d = htfd_pkg::POS_T_HI;
      endcase
    end
  end

  always_comb begin
    crc_d      = crc_q;
    high_d     = high_q;
    raw_temp_d = raw_temp_q;
    raw_hum_d  = raw_hum_q;
    temp_bad_d = temp_bad_q;
    push_o     = 1'b0;
    if (accept) begin
      case (pos_cur)
        htfd_pkg::POS_T_HI, htfd_pkg::POS_H_HI: begin
          high_d = s_byte_i;
          crc_d  = crc_next;
        end
        htfd_pkg::POS_T_LO: begin
          raw_temp_d = {high_q, s_byte_i};
          crc_d      = crc_next;
        end
        htfd_pkg::POS_H_LO: begin
          raw_hum_d = {high_q, s_byte_i};
          crc_d     = crc_next;
        end
        htfd_pkg::POS_T_CRC: begin
          temp_bad_d = (crc_cur != s_byte_i);
          crc_d      = htfd_pkg::CRC_INIT;
        end
        htfd_pkg::POS_H_CRC: begin
          push_o = 1'b1;
          crc_d  = htfd_pkg::CRC_INIT;
        end
        default: begin
          crc_d = crc_q;
        end
      endcase
    end
  end

  assign frame_o.raw_temp = raw_temp_q;
  assign frame_o.raw_hum  = raw_hum_q;
  assign frame_o.temp_bad = temp_bad_q;
  assign frame_o.hum_bad  = (crc_cur != s_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= htfd_pkg::POS_T_HI;
      crc_q <= htfd_pkg::CRC_INIT;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    high_q     <= high_d;
    raw_temp_q <= raw_temp_d;
    raw_hum_q  <= raw_hum_d;
    temp_bad_q <= temp_bad_d;
  end

endmodule

>>> src/htfd_queue.sv
// ----------------------------------------------------------------------------
// htfd_queue
// small fifo of checked frames between intake and conversion
// ----------------------------------------------------------------------------
module htfd_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  htfd_pkg::frame_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output htfd_pkg::frame_t data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  htfd_pkg::frame_t    mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/htfd_back.sv
// ----------------------------------------------------------------------------
// htfd_back
// two stage conversion of raw words to centi-units with an output register
// ----------------------------------------------------------------------------
module htfd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  htfd_pkg::frame_t q_data_i,
  output logic             q_pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [14:0]      m_temp_o,
  output logic [13:0]      m_hum_o,
  output logic             m_temp_bad_o,
  output logic             m_hum_bad_o
);

  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [13:0] HumScale   = 14'd10000;
  localparam logic [14:0] TempOffset = 15'd4500;

  logic        en;
  logic        p1_v_q;
  logic [30:0] temp_prod_q;
  logic [29:0] hum_prod_q;
  logic        p1_tbad_q, p1_hbad_q;
  logic [31:0] temp_sum;
  logic [30:0] hum_sum;
  logic [14:0] temp_quot;
  logic [13:0] hum_quot;
  logic        out_v_q;
  logic [14:0] temp_q;
  logic [13:0] hum_q;
  logic        tbad_q, hbad_q;

  assign en      = !out_v_q || m_ready_i;
  assign q_pop_o = q_valid_i && en;

  // x / 65535 as (x + (x >> 16) + 1) >> 16, exact for these ranges
  assign temp_sum  = 32'(temp_prod_q) + 32'(temp_prod_q[30:16]) + 32'd1;
  assign hum_sum   = 31'(hum_prod_q) + 31'(hum_prod_q[29:16]) + 31'd1;
  assign temp_quot = temp_sum[30:16];
  assign hum_quot  = hum_sum[29:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q  <= q_valid_i;
      out_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_prod_q <= 31'(q_data_i.raw_temp) * 31'(TempScale);
      hum_prod_q  <= 30'(q_data_i.raw_hum) * 30'(HumScale);
      p1_tbad_q   <= q_data_i.temp_bad;
      p1_hbad_q   <= q_data_i.hum_bad;
      temp_q      <= temp_quot - TempOffset;
      hum_q       <= hum_quot;
      tbad_q      <= p1_tbad_q;
      hbad_q      <= p1_hbad_q;
    end
  end

  assign m_valid_o    = out_v_q;
  assign m_temp_o     = temp_q;
  assign m_hum_o      = hum_q;
  assign m_temp_bad_o = tbad_q;
  assign m_hum_bad_o  = hbad_q;

endmodule

>>> src/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// crc-8 checked six byte humidity and temperature frame decoder
// ----------------------------------------------------------------------------
// Takes one sensor response byte per clock (temp hi, temp lo, crc, hum hi,
// hum lo, crc; tuser marks a frame start) and gives one word per frame with
// temperature in 0.01 degC, humidity in 0.01 %RH and two crc mismatch flags.
// The intake updates the crc as each byte is accepted, so a byte is taken
// every cycle while the frame queue has room; the result is registered after
// the sixth byte in the queue memory, then in the two conversion stages
// (multiply, then divide-by-65535 add). QueueDepth frames can wait while
// the output is stalled.
`include "humidity_temp_frame_decoder_assert.svh"

module humidity_temp_frame_decoder #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
  output logic [1:0]  m_axis_tuser    // [0] temp_check_bad, [1] hum_check_bad
);

  htfd_pkg::frame_t push_frame, pop_frame;
  logic             push, full, q_valid, pop;
  logic [14:0]      temp;
  logic [13:0]      hum;
  logic             temp_bad, hum_bad;

  htfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_byte_i  (s_axis_tdata),
    .s_start_i (s_axis_tuser[0]),
    .s_ready_o (s_axis_tready),
    .full_i    (full),
    .push_o    (push),
    .frame_o   (push_frame)
  );

  htfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_frame),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (pop_frame)
  );

  htfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (pop_frame),
    .q_pop_o      (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_temp_o     (temp),
    .m_hum_o      (hum),
    .m_temp_bad_o (temp_bad),
    .m_hum_bad_o  (hum_bad)
  );

  assign m_axis_tdata = {3'b000, hum, temp};
  assign m_axis_tuser = {hum_bad, temp_bad};

  `HTFD_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push && full)
  `HTFD_ASSERT(a_temp_range, clk_i, rst_ni, m_axis_tvalid |-> ($signed(temp) >= -15'sd4500 && $signed(temp) <= 15'sd13000))
  `HTFD_ASSERT(a_hum_range, clk_i, rst_ni, m_axis_tvalid |-> (hum <= 14'd10000))

endmodule

>>> dv/humidity_temp_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker
// Watches both stream channels of the frame decoder. Every accepted input
// byte goes through a cycle-free decoder of the six byte sensor frame. That
// decoder tracks the byte position, the crc-8 of each word and the raw words.
// On each sixth byte it queues the expected temperature, humidity and crc
// flags. Each output word is compared field by field with the oldest queued
// reading. The mismatch count and the number of readings still owed go back
// to the testbench top.
// ----------------------------------------------------------------------------
package htfd_tb_pkg;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ htfd_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

module humidity_temp_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
  input  logic [1:0]  m_axis_tuser,   // [0] temp_check_bad, [1] hum_check_bad
  output int          mismatch_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic               temp_bad;
    logic               hum_bad;
  } reading_t;

  reading_t   readings_q[$];
  logic [2:0] frame_pos = htfd_pkg::POS_T_HI;
  logic [7:0] word_crc = htfd_pkg::CRC_INIT;
  logic [7:0] high_byte = '0;
  logic [15:0] raw_temp = '0;
  logic [15:0] raw_hum = '0;
  logic       temp_bad = 1'b0;
  int         mismatch_cnt = 0;

  task automatic decode_byte(input logic [7:0] b, input logic frame_start);
    logic [2:0] pos;
    reading_t   r;
    int         temp;
    pos = frame_pos;
    if (frame_start || pos > htfd_pkg::POS_H_CRC) begin
      pos = htfd_pkg::POS_T_HI;
      word_crc = htfd_pkg::CRC_INIT;
    end
    case (pos)
      htfd_pkg::POS_T_HI, htfd_pkg::POS_H_HI: begin
        high_byte = b;
        word_crc = htfd_tb_pkg::crc8_feed(word_crc, b);
        frame_pos = (pos == htfd_pkg::POS_T_HI) ? htfd_pkg::POS_T_LO : htfd_pkg::POS_H_LO;
      end
      htfd_pkg::POS_T_LO: begin
        raw_temp = {high_byte, b};
        word_crc = htfd_tb_pkg::crc8_feed(word_crc, b);
        frame_pos = htfd_pkg::POS_T_CRC;
      end
      htfd_pkg::POS_H_LO: begin
        raw_hum = {high_byte, b};
        word_crc = htfd_tb_pkg::crc8_feed(word_crc, b);
        frame_pos = htfd_pkg::POS_H_CRC;
      end
      htfd_pkg::POS_T_CRC: begin
        temp_bad = (word_crc != b);
        word_crc = htfd_pkg::CRC_INIT;
        frame_pos = htfd_pkg::POS_H_HI;
      end
      default: begin
        temp = -4500 + int'((17500 * longint'(raw_temp)) / 65535);
        r.temp_centi = 15'(temp);
        r.hum_centi = 14'((10000 * longint'(raw_hum)) / 65535);
        r.temp_bad = temp_bad;
        r.hum_bad = (word_crc != b);
        readings_q.push_back(r);
        word_crc = htfd_pkg::CRC_INIT;
        frame_pos = htfd_pkg::POS_T_HI;
      end
    endcase
  endtask

  task automatic flag_field(input string field, input int want, input int got);
    if (mismatch_cnt < 10) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin : watch
    reading_t got;
    reading_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[14:0], m_axis_tdata[28:15], m_axis_tuser[0], m_axis_tuser[1]};
        if (readings_q.size() == 0) begin
          flag_field("unexpected word, temperature_centi", 0, int'(got.temp_centi));
        end else begin
          want = readings_q.pop_front();
          if (got.temp_centi !== want.temp_centi) begin
            flag_field("temperature_centi", int'(want.temp_centi), int'(got.temp_centi));
          end
          if (got.hum_centi !== want.hum_centi) begin
            flag_field("humidity_centi", int'(want.hum_centi), int'(got.hum_centi));
          end
          if (got.temp_bad !== want.temp_bad) begin
            flag_field("temp_check_bad", int'(want.temp_bad), int'(got.temp_bad));
          end
          if (got.hum_bad !== want.hum_bad) begin
            flag_field("hum_check_bad", int'(want.hum_bad), int'(got.hum_bad));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tuser[0]);
      end
    end
    mismatch_cnt_o <= mismatch_cnt;
    pending_o <= readings_q.size();
  end

endmodule

>>> dv/tb_humidity_temp_frame_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_humidity_temp_frame_decoder
// Stimulus and verdict for the humidity and temperature frame decoder. A
// directed opening covers the extreme raw words, each crc flag, the wrap
// from one frame into the next and a restart in the middle of a frame. Then
// random frames follow, mostly well formed with some bad check bytes, plus
// noise and cut-off frames. The run goes through three idle phases on the
// two sides and drains fully between phases. The checker instance predicts
// and compares the results.
// ----------------------------------------------------------------------------
module tb_humidity_temp_frame_decoder;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] byte_in
  logic [0:0]  s_axis_tuser = '0;    // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [14:0] temperature_centi, [28:15] humidity_centi
  logic [1:0]  m_axis_tuser;         // [0] temp_check_bad, [1] hum_check_bad
  int          mismatch_cnt;
  int          pending;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          bytes_sent = 0;

  humidity_temp_frame_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  humidity_temp_frame_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // each idle cycle is drawn on its own
  task automatic send_byte(input logic [7:0] b, input logic frame_start);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= frame_start;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // crc error masks flip bits of the check bytes, nbytes below six cuts the frame
  task automatic send_frame(input logic [15:0] raw_t, input logic [15:0] raw_h,
                            input logic [7:0] t_err, input logic [7:0] h_err,
                            input logic frame_start, input int nbytes);
    logic [7:0] frame [6];
    frame[0] = raw_t[15:8];
    frame[1] = raw_t[7:0];
    frame[2] = htfd_tb_pkg::crc8_feed(htfd_tb_pkg::crc8_feed(htfd_pkg::CRC_INIT,
                                                             raw_t[15:8]),
                                      raw_t[7:0]) ^ t_err;
    frame[3] = raw_h[15:8];
    frame[4] = raw_h[7:0];
    frame[5] = htfd_tb_pkg::crc8_feed(htfd_tb_pkg::crc8_feed(htfd_pkg::CRC_INIT,
                                                             raw_h[15:8]),
                                      raw_h[7:0]) ^ h_err;
    for (int i = 0; i < nbytes; i++) begin
      send_byte(frame[i], (i == 0) ? frame_start : 1'b0);
    end
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_crc_err();
    return ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
  endfunction

  task automatic run_random(input int count);
    int stop;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      case ($urandom_range(19))
        0: begin
          repeat ($urandom_range(5, 1)) send_byte(8'($urandom), $urandom_range(3) == 0);
        end
        1: begin
          send_frame(pick_raw(), pick_raw(), pick_crc_err(), pick_crc_err(), 1'b1,
                     $urandom_range(5, 1));
        end
        default: begin
          send_frame(pick_raw(), pick_raw(), pick_crc_err(), pick_crc_err(),
                     $urandom_range(3) != 0, 6);
        end
      endcase
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, both flags, wrap without start, restart mid frame
    send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b1, 6);
    send_frame(16'hFFFF, 16'hFFFF, 8'h01, 8'h00, 1'b0, 6);
    send_frame(16'h1234, 16'h5678, 8'h00, 8'h00, 1'b0, 3);
    send_frame(16'h8000, 16'h7FFF, 8'h00, 8'h80, 1'b1, 6);
    drain();

    tx_idle_pct = 27;
    rx_idle_pct <= 53;
    run_random(510);
    drain();

    tx_idle_pct = 53;
    rx_idle_pct <= 27;
    run_random(510);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_random(510);
    drain();
    repeat (20) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
